[hdl/tlak_pkg.sv]
`default_nettype none

package tlak_pkg;

  // Command codes carried on the func field.
  localparam logic [1:0] FUNC_SET_XY       = 2'd0;
  localparam logic [1:0] FUNC_SET_POLAR    = 2'd1;
  localparam logic [1:0] FUNC_SET_SHOULDER = 2'd2;
  localparam logic [1:0] FUNC_SET_ELBOW    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEN_AB      = 2'd0;
  localparam logic [1:0] CFG_LEN_BC      = 2'd1;
  localparam logic [1:0] CFG_ELBOW_UPPER = 2'd2;

  // Iteration counts of the shared units.
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 25;
  localparam int DIV_STEPS    = 24;

  // Gain-compensated CORDIC start vector, Q2.30.
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic signed [18:0] POS_MAX = 19'sd262143;
  localparam logic signed [18:0] POS_MIN = -19'sd262144;
  localparam logic [17:0]        RAD_MAX = 18'd262143;

  // Cosine of zero in Q2.24 and its square in Q.48.
  localparam logic signed [25:0] COS_ONE = 26'sd16777216;
  localparam logic [49:0]        ONE48   = 50'h1_0000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_P_SQX,
    S_P_SQY,
    S_P_SQRT,
    S_P_ATAN,
    S_P_END,
    S_MP_CHK,
    S_MP_CS,
    S_MP_MX,
    S_MP_MY,
    S_MP_WY,
    S_SV_AA,
    S_SV_BB,
    S_SV_RR,
    S_SV_AB,
    S_SV_AR,
    S_SV_DEN,
    S_AC_CLAMP,
    S_AC_DIV,
    S_AC_CSQ,
    S_AC_SQRT,
    S_AC_ATAN,
    S_EL_CS,
    S_EL_MX,
    S_EL_MY,
    S_EL_WY,
    S_F3_CS,
    S_F3_MX,
    S_F3_MY,
    S_F3_WY,
    S_DONE
  } state_t;

  // Arctangent of 2^-i in turns scaled by 2^32.
  function automatic logic [31:0] atan_coef(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10679838;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41722;
      4'd15:   v = 32'd20861;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Round a Q.30 product half up to Q.8 positions.
  function automatic logic signed [29:0] rnd30(input logic signed [59:0] p);
    logic signed [59:0] t;
    t = p + 60'sd536870912;
    return $signed(t[59:30]);
  endfunction

  // Saturate to the signed 19-bit position range.
  function automatic logic signed [18:0] sat19(input logic signed [31:0] v);
    logic signed [18:0] r;
    if (v > 32'sd262143) begin
      r = POS_MAX;
    end else if (v < -32'sd262144) begin
      r = POS_MIN;
    end else begin
      r = $signed(v[18:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/tlak_cordic.sv]
`default_nettype none

module tlak_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               vec,
  input  wire logic [15:0]        ang,
  input  wire logic signed [33:0] vx,
  input  wire logic signed [33:0] vy,
  output logic                    busy,
  output logic                    done,
  output logic signed [33:0]      cos_out,
  output logic signed [33:0]      sin_out,
  output logic [15:0]             ang_out
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic [31:0]        z;
  logic [3:0]         it;
  logic               mode_vec;
  logic               flip;
  logic               zero_in;

  logic [31:0]        a_full;
  logic [31:0]        a_quarter;
  logic               a_flip;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic               pos;
  logic [31:0]        coef;
  logic [31:0]        z_rnd;

  // Fold the start angle into the right half plane.
  always_comb begin
    a_full    = {ang, 16'h0000};
    a_quarter = a_full + 32'h4000_0000;
    a_flip    = a_quarter[31];
  end

  // One micro-rotation per cycle through a shared shifter.
  always_comb begin
    dx   = y >>> it;
    dy   = x >>> it;
    coef = tlak_pkg::atan_coef(it);
    pos  = mode_vec ? y[33] : ~z[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        it       <= '0;
        mode_vec <= vec;
        if (vec) begin
          flip    <= 1'b0;
          zero_in <= (vx == '0) && (vy == '0);
          if (vx[33]) begin
            x <= -vx;
            y <= -vy;
            z <= 32'h8000_0000;
          end else begin
            x <= vx;
            y <= vy;
            z <= 32'h0000_0000;
          end
        end else begin
          flip    <= a_flip;
          zero_in <= 1'b0;
          x       <= tlak_pkg::CORDIC_X0;
          y       <= '0;
          z       <= a_flip ? a_full + 32'h8000_0000 : a_full;
        end
      end else if (busy) begin
        if (pos) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - coef;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + coef;
        end
        it <= it + 4'd1;
        if (it == 4'(tlak_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Undo the fold and round the accumulated angle.
  always_comb begin
    z_rnd   = z + 32'h0000_8000;
    cos_out = flip ? -x : x;
    sin_out = flip ? -y : y;
    ang_out = zero_in ? 16'h0000 : z_rnd[31:16];
  end

endmodule

`default_nettype wire

[hdl/tlak_sqrt.sv]
`default_nettype none

module tlak_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [49:0] rad,
  output logic             busy,
  output logic             done,
  output logic [24:0]      root
);

  logic [49:0] sr;
  logic [26:0] rem;
  logic [4:0]  cnt;
  logic [28:0] t;
  logic [28:0] trial;
  logic        ge;

  // One result bit per cycle from the next pair of radicand bits.
  always_comb begin
    t     = {rem, sr[49:48]};
    trial = {2'b00, root, 2'b01};
    ge    = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sr   <= rad;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= 27'(t - trial);
        end else begin
          rem <= t[26:0];
        end
        root <= {root[23:0], ge};
        sr   <= {sr[47:0], 2'b00};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(tlak_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/two_link_arm_kinematics_core.sv]
// One sequencer shares the 16-step CORDIC, 25-step square root and 24-step divider.
// Throughput: one command at a time; the next beat is taken once the result has
// moved into the output register. Reset is synchronous: pose clears to zero, link
// lengths return to 256 (1.0) and the upper elbow solution is selected.
`default_nettype none

module two_link_arm_kinematics_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic               as_delta,
  input  wire logic signed [18:0] pos_x,
  input  wire logic signed [18:0] pos_y,
  input  wire logic signed [18:0] radius,
  input  wire logic [15:0]        angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    accepted,
  output logic signed [18:0]      tip_x,
  output logic signed [18:0]      tip_y,
  output logic [17:0]             tip_radius,
  output logic [15:0]             tip_angle,
  output logic signed [18:0]      elbow_x,
  output logic signed [18:0]      elbow_y,
  output logic [15:0]             shoulder_angle,
  output logic [15:0]             elbow_angle,
  output logic [15:0]             link_two_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  tlak_pkg::state_t state;
  tlak_pkg::state_t state_next;

  // Configuration.
  logic [15:0] len_ab;
  logic [15:0] len_bc;
  logic        elbow_upper;

  // Arm pose.
  logic signed [18:0] st_tip_x;
  logic signed [18:0] st_tip_y;
  logic [17:0]        st_tip_r;
  logic [15:0]        st_tip_a;
  logic signed [18:0] st_elbow_x;
  logic signed [18:0] st_elbow_y;
  logic [15:0]        st_shoulder;
  logic [15:0]        st_elbow_a;

  // Latched command.
  logic [1:0]         op_func;
  logic               op_delta;
  logic signed [18:0] op_pos_x;
  logic signed [18:0] op_pos_y;
  logic signed [18:0] op_radius;
  logic [15:0]        op_angle;

  // Working registers.
  logic signed [18:0] nx;
  logic signed [18:0] ny;
  logic [17:0]        nr;
  logic [15:0]        na;
  logic               acc;
  logic               launched;
  logic [36:0]        sqx;
  logic [31:0]        sq_a;
  logic [31:0]        sq_b;
  logic [35:0]        sq_r;
  logic signed [38:0] ac_num;
  logic [35:0]        ac_den;
  logic [35:0]        den2;
  logic               ac_idx;
  logic signed [25:0] ac_c;
  logic [24:0]        ac_sq;

  // Shared multiplier.
  logic               mul_en;
  logic signed [25:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [59:0] prod;

  // Shared units.
  logic               cor_start;
  logic               cor_vec;
  logic [15:0]        cor_ang;
  logic signed [33:0] cor_vx;
  logic signed [33:0] cor_vy;
  logic               cor_busy;
  logic               cor_done;
  logic signed [33:0] cor_cos;
  logic signed [33:0] cor_sin;
  logic [15:0]        cor_ang_out;
  logic               sq_start;
  logic [49:0]        sq_rad;
  logic               sq_busy;
  logic               sq_done;
  logic [24:0]        sq_root;
  logic               unit_done;

  // Divider for the cosine ratio.
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [4:0]         div_cnt;
  logic [35:0]        div_rem;
  logic [35:0]        div_dd;
  logic [23:0]        div_q;
  logic [36:0]        div_t;
  logic               div_ge;
  logic [38:0]        num_abs;

  // Miscellaneous combinational values.
  logic signed [19:0] reach_lo;
  logic signed [19:0] reach_hi;
  logic               reach_ok;
  logic signed [19:0] polar_sum;
  logic [17:0]        polar_r;
  logic [15:0]        f3_t;
  logic [17:0]        root_r;
  logic signed [29:0] rnd_val;
  logic signed [18:0] sat_rnd;
  logic signed [18:0] f3_x;
  logic signed [18:0] f3_y;
  logic               num_ge;
  logic               num_le;
  logic               need_div;
  logic signed [18:0] xy_x;
  logic signed [18:0] xy_y;
  logic               out_load;

  assign in_ready  = (state == tlak_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign unit_done = cor_done | sq_done | div_done;
  assign out_load  = (state == tlak_pkg::S_DONE) && (!out_valid || out_ready);

  // Reach test: len_ab - len_bc < r < len_ab + len_bc.
  always_comb begin
    reach_lo = $signed({4'b0000, len_ab}) - $signed({4'b0000, len_bc});
    reach_hi = $signed({4'b0000, len_ab}) + $signed({4'b0000, len_bc});
    reach_ok = (reach_lo < $signed({2'b00, nr})) && ($signed({2'b00, nr}) < reach_hi);
  end

  // Command operand arithmetic.
  always_comb begin
    polar_sum = op_delta ? $signed({2'b00, st_tip_r}) + $signed({op_radius[18], op_radius})
                         : $signed({op_radius[18], op_radius});
    if (polar_sum[19]) begin
      polar_r = '0;
    end else if (polar_sum > $signed({2'b00, tlak_pkg::RAD_MAX})) begin
      polar_r = tlak_pkg::RAD_MAX;
    end else begin
      polar_r = polar_sum[17:0];
    end
    xy_x = tlak_pkg::sat19(op_delta ? 32'(st_tip_x) + 32'(op_pos_x) : 32'(op_pos_x));
    xy_y = tlak_pkg::sat19(op_delta ? 32'(st_tip_y) + 32'(op_pos_y) : 32'(op_pos_y));
    if (elbow_upper) begin
      f3_t = st_shoulder + st_elbow_a - 16'h8000;
    end else begin
      f3_t = st_shoulder + 16'h8000 - st_elbow_a;
    end
    root_r = (sq_root > 25'(tlak_pkg::RAD_MAX)) ? tlak_pkg::RAD_MAX : sq_root[17:0];
    rnd_val = tlak_pkg::rnd30(prod);
    sat_rnd = tlak_pkg::sat19(32'(rnd_val));
    f3_x    = tlak_pkg::sat19(32'(st_elbow_x) + 32'(rnd_val));
    f3_y    = tlak_pkg::sat19(32'(st_elbow_y) + 32'(rnd_val));
  end

  // Cosine clamp ahead of the divider.
  always_comb begin
    num_ge   = ac_num >= $signed({3'b000, ac_den});
    num_le   = ac_num <= -$signed({3'b000, ac_den});
    need_div = (ac_den != '0) && !num_ge && !num_le;
    num_abs  = ac_num[38] ? 39'(-ac_num) : 39'(ac_num);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlak_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, unit launches and multiplier operands.
  always_comb begin
    state_next = state;
    cor_start  = 1'b0;
    cor_vec    = 1'b0;
    cor_ang    = '0;
    cor_vx     = '0;
    cor_vy     = '0;
    sq_start   = 1'b0;
    sq_rad     = '0;
    div_start  = 1'b0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      tlak_pkg::S_IDLE: begin
        if (in_valid) state_next = tlak_pkg::S_LOAD;
      end
      tlak_pkg::S_LOAD: begin
        case (op_func)
          tlak_pkg::FUNC_SET_XY:       state_next = tlak_pkg::S_P_SQX;
          tlak_pkg::FUNC_SET_POLAR:    state_next = tlak_pkg::S_MP_CHK;
          tlak_pkg::FUNC_SET_SHOULDER: begin
            if (!op_delta || op_angle != '0) begin
              state_next = tlak_pkg::S_MP_CHK;
            end else begin
              state_next = tlak_pkg::S_DONE;
            end
          end
          default:                     state_next = tlak_pkg::S_F3_CS;
        endcase
      end
      // Cartesian to polar.
      tlak_pkg::S_P_SQX: begin
        mul_en     = 1'b1;
        mul_a      = 26'(nx);
        mul_b      = 34'(nx);
        state_next = tlak_pkg::S_P_SQY;
      end
      tlak_pkg::S_P_SQY: begin
        mul_en     = 1'b1;
        mul_a      = 26'(ny);
        mul_b      = 34'(ny);
        state_next = tlak_pkg::S_P_SQRT;
      end
      tlak_pkg::S_P_SQRT: begin
        sq_rad   = {12'h000, {1'b0, sqx} + {1'b0, prod[36:0]}};
        sq_start = !launched;
        if (sq_done) state_next = tlak_pkg::S_P_ATAN;
      end
      tlak_pkg::S_P_ATAN: begin
        cor_vec   = 1'b1;
        cor_vx    = {{7{nx[18]}}, nx, 8'h00};
        cor_vy    = {{7{ny[18]}}, ny, 8'h00};
        cor_start = !launched;
        if (cor_done) state_next = tlak_pkg::S_P_END;
      end
      tlak_pkg::S_P_END: begin
        if (op_func == tlak_pkg::FUNC_SET_ELBOW) begin
          state_next = tlak_pkg::S_DONE;
        end else if (reach_ok) begin
          state_next = tlak_pkg::S_SV_AA;
        end else begin
          state_next = tlak_pkg::S_DONE;
        end
      end
      // Polar tip move.
      tlak_pkg::S_MP_CHK: begin
        state_next = reach_ok ? tlak_pkg::S_MP_CS : tlak_pkg::S_DONE;
      end
      tlak_pkg::S_MP_CS: begin
        cor_ang   = na;
        cor_start = !launched;
        if (cor_done) state_next = tlak_pkg::S_MP_MX;
      end
      tlak_pkg::S_MP_MX: begin
        mul_en     = 1'b1;
        mul_a      = $signed({8'h00, nr});
        mul_b      = cor_cos;
        state_next = tlak_pkg::S_MP_MY;
      end
      tlak_pkg::S_MP_MY: begin
        mul_en     = 1'b1;
        mul_a      = $signed({8'h00, nr});
        mul_b      = cor_sin;
        state_next = tlak_pkg::S_MP_WY;
      end
      tlak_pkg::S_MP_WY: state_next = tlak_pkg::S_SV_AA;
      // Squares and products for the law of cosines.
      tlak_pkg::S_SV_AA: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_ab});
        mul_b      = $signed({18'h00000, len_ab});
        state_next = tlak_pkg::S_SV_BB;
      end
      tlak_pkg::S_SV_BB: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_bc});
        mul_b      = $signed({18'h00000, len_bc});
        state_next = tlak_pkg::S_SV_RR;
      end
      tlak_pkg::S_SV_RR: begin
        mul_en     = 1'b1;
        mul_a      = $signed({8'h00, st_tip_r});
        mul_b      = $signed({16'h0000, st_tip_r});
        state_next = tlak_pkg::S_SV_AB;
      end
      tlak_pkg::S_SV_AB: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_ab});
        mul_b      = $signed({18'h00000, len_bc});
        state_next = tlak_pkg::S_SV_AR;
      end
      tlak_pkg::S_SV_AR: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_ab});
        mul_b      = $signed({16'h0000, st_tip_r});
        state_next = tlak_pkg::S_SV_DEN;
      end
      tlak_pkg::S_SV_DEN: state_next = tlak_pkg::S_AC_CLAMP;
      // Arccosine: clamp or divide, then atan2(sqrt(1 - c^2), c).
      tlak_pkg::S_AC_CLAMP: begin
        state_next = need_div ? tlak_pkg::S_AC_DIV : tlak_pkg::S_AC_CSQ;
      end
      tlak_pkg::S_AC_DIV: begin
        div_start = !launched;
        if (div_done) state_next = tlak_pkg::S_AC_CSQ;
      end
      tlak_pkg::S_AC_CSQ: begin
        mul_en     = 1'b1;
        mul_a      = ac_c;
        mul_b      = 34'(ac_c);
        state_next = tlak_pkg::S_AC_SQRT;
      end
      tlak_pkg::S_AC_SQRT: begin
        sq_rad   = tlak_pkg::ONE48 - prod[49:0];
        sq_start = !launched;
        if (sq_done) state_next = tlak_pkg::S_AC_ATAN;
      end
      tlak_pkg::S_AC_ATAN: begin
        cor_vec   = 1'b1;
        cor_vx    = 34'(ac_c);
        cor_vy    = $signed({9'h000, ac_sq});
        cor_start = !launched;
        if (cor_done) begin
          state_next = ac_idx ? tlak_pkg::S_EL_CS : tlak_pkg::S_AC_CLAMP;
        end
      end
      // Elbow position from the shoulder angle.
      tlak_pkg::S_EL_CS: begin
        cor_ang   = st_shoulder;
        cor_start = !launched;
        if (cor_done) state_next = tlak_pkg::S_EL_MX;
      end
      tlak_pkg::S_EL_MX: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_ab});
        mul_b      = cor_cos;
        state_next = tlak_pkg::S_EL_MY;
      end
      tlak_pkg::S_EL_MY: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_ab});
        mul_b      = cor_sin;
        state_next = tlak_pkg::S_EL_WY;
      end
      tlak_pkg::S_EL_WY: state_next = tlak_pkg::S_DONE;
      // Forward kinematics for the elbow command.
      tlak_pkg::S_F3_CS: begin
        cor_ang   = f3_t;
        cor_start = !launched;
        if (cor_done) state_next = tlak_pkg::S_F3_MX;
      end
      tlak_pkg::S_F3_MX: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_bc});
        mul_b      = cor_cos;
        state_next = tlak_pkg::S_F3_MY;
      end
      tlak_pkg::S_F3_MY: begin
        mul_en     = 1'b1;
        mul_a      = $signed({10'h000, len_bc});
        mul_b      = cor_sin;
        state_next = tlak_pkg::S_F3_WY;
      end
      tlak_pkg::S_F3_WY: state_next = tlak_pkg::S_P_SQX;
      tlak_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = tlak_pkg::S_IDLE;
      end
      default: state_next = tlak_pkg::S_IDLE;
    endcase
  end

  // Multiplier output register.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Restoring divider: one quotient bit of |num| * 2^24 / den per cycle.
  always_comb begin
    div_t  = {div_rem, 1'b0};
    div_ge = div_t >= {1'b0, div_dd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
        div_rem  <= num_abs[35:0];
        div_dd   <= ac_den;
        div_q    <= '0;
      end else if (div_busy) begin
        if (div_ge) begin
          div_rem <= 36'(div_t - {1'b0, div_dd});
        end else begin
          div_rem <= div_t[35:0];
        end
        div_q   <= {div_q[22:0], div_ge};
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'(tlak_pkg::DIV_STEPS - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  tlak_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .vec     (cor_vec),
    .ang     (cor_ang),
    .vx      (cor_vx),
    .vy      (cor_vy),
    .busy    (cor_busy),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin),
    .ang_out (cor_ang_out)
  );

  tlak_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sq_rad),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_ab      <= 16'd256;
      len_bc      <= 16'd256;
      elbow_upper <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlak_pkg::CFG_LEN_AB:      len_ab      <= cfg_data;
        tlak_pkg::CFG_LEN_BC:      len_bc      <= cfg_data;
        tlak_pkg::CFG_ELBOW_UPPER: elbow_upper <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command latch.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func   <= func;
      op_delta  <= as_delta;
      op_pos_x  <= pos_x;
      op_pos_y  <= pos_y;
      op_radius <= radius;
      op_angle  <= angle;
    end
  end

  // Unit launch tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (cor_start || sq_start || div_start) begin
      launched <= 1'b1;
    end else if (unit_done) begin
      launched <= 1'b0;
    end
  end

  // Pose and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_tip_x    <= '0;
      st_tip_y    <= '0;
      st_tip_r    <= '0;
      st_tip_a    <= '0;
      st_elbow_x  <= '0;
      st_elbow_y  <= '0;
      st_shoulder <= '0;
      st_elbow_a  <= '0;
      acc         <= 1'b0;
    end else begin
      case (state)
        tlak_pkg::S_LOAD: begin
          acc <= 1'b0;
          case (op_func)
            tlak_pkg::FUNC_SET_XY: begin
              nx <= xy_x;
              ny <= xy_y;
            end
            tlak_pkg::FUNC_SET_POLAR: begin
              nr <= polar_r;
              na <= op_delta ? st_tip_a + op_angle : op_angle;
            end
            tlak_pkg::FUNC_SET_SHOULDER: begin
              nr <= st_tip_r;
              na <= st_tip_a + (op_delta ? op_angle : op_angle - st_shoulder);
            end
            default: begin
              st_elbow_a <= op_delta ? st_elbow_a + op_angle : op_angle;
            end
          endcase
        end
        tlak_pkg::S_P_SQY: sqx <= prod[36:0];
        tlak_pkg::S_P_SQRT: begin
          if (sq_done) nr <= root_r;
        end
        tlak_pkg::S_P_ATAN: begin
          if (cor_done) na <= cor_ang_out;
        end
        tlak_pkg::S_P_END: begin
          if (op_func == tlak_pkg::FUNC_SET_ELBOW) begin
            st_tip_r <= nr;
            st_tip_a <= na;
          end else if (reach_ok) begin
            st_tip_x <= nx;
            st_tip_y <= ny;
            st_tip_r <= nr;
            st_tip_a <= na;
            acc      <= 1'b1;
          end
        end
        tlak_pkg::S_MP_MY: st_tip_x <= sat_rnd;
        tlak_pkg::S_MP_WY: begin
          st_tip_y <= sat_rnd;
          st_tip_r <= nr;
          st_tip_a <= na;
          acc      <= 1'b1;
        end
        tlak_pkg::S_SV_BB: sq_a <= prod[31:0];
        tlak_pkg::S_SV_RR: sq_b <= prod[31:0];
        tlak_pkg::S_SV_AB: sq_r <= prod[35:0];
        tlak_pkg::S_SV_AR: begin
          ac_den <= {prod[34:0], 1'b0};
          ac_num <= $signed({7'h00, sq_a}) + $signed({7'h00, sq_b})
                    - $signed({3'b000, sq_r});
          ac_idx <= 1'b0;
        end
        tlak_pkg::S_SV_DEN: den2 <= {prod[34:0], 1'b0};
        tlak_pkg::S_AC_CLAMP: begin
          if (ac_den == '0) begin
            if (ac_num == '0) begin
              ac_c <= '0;
            end else begin
              ac_c <= ac_num[38] ? -tlak_pkg::COS_ONE : tlak_pkg::COS_ONE;
            end
          end else if (num_ge) begin
            ac_c <= tlak_pkg::COS_ONE;
          end else if (num_le) begin
            ac_c <= -tlak_pkg::COS_ONE;
          end
        end
        tlak_pkg::S_AC_DIV: begin
          if (div_done) begin
            ac_c <= ac_num[38] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
          end
        end
        tlak_pkg::S_AC_SQRT: begin
          if (sq_done) ac_sq <= sq_root;
        end
        tlak_pkg::S_AC_ATAN: begin
          if (cor_done) begin
            if (!ac_idx) begin
              st_elbow_a <= cor_ang_out;
              ac_num     <= $signed({7'h00, sq_a}) + $signed({3'b000, sq_r})
                            - $signed({7'h00, sq_b});
              ac_den     <= den2;
              ac_idx     <= 1'b1;
            end else begin
              st_shoulder <= st_tip_a + (elbow_upper ? cor_ang_out : 16'(16'h0 - cor_ang_out));
            end
          end
        end
        tlak_pkg::S_EL_MY: st_elbow_x <= sat_rnd;
        tlak_pkg::S_EL_WY: st_elbow_y <= sat_rnd;
        tlak_pkg::S_F3_MY: st_tip_x <= f3_x;
        tlak_pkg::S_F3_WY: begin
          st_tip_y <= f3_y;
          nx       <= st_tip_x;
          ny       <= f3_y;
          acc      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: holds a finished result until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted       <= acc;
      tip_x          <= st_tip_x;
      tip_y          <= st_tip_y;
      tip_radius     <= st_tip_r;
      tip_angle      <= st_tip_a;
      elbow_x        <= st_elbow_x;
      elbow_y        <= st_elbow_y;
      shoulder_angle <= st_shoulder;
      elbow_angle    <= st_elbow_a;
      link_two_angle <= (elbow_upper ? st_shoulder : 16'(16'h0 - st_shoulder)) + st_elbow_a;
    end
  end

`ifndef SYNTH
  // At most one shared unit runs at a time.
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cor_busy, sq_busy, div_busy}))
    else $error("more than one shared unit busy");

  // An accepted command is dispatched in the next cycle.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == tlak_pkg::S_LOAD))
    else $error("accepted command not dispatched");

  // Finishing a command always presents a result.
  a_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == tlak_pkg::S_IDLE))
    else $error("finished command without result");

  // The divider only runs inside the arccosine step.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == tlak_pkg::S_AC_DIV))
    else $error("divider busy outside its step");

  // A Cartesian tip move out of reach leaves the tip where it was.
  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == tlak_pkg::S_P_END && op_func != tlak_pkg::FUNC_SET_ELBOW && !reach_ok)
    |=> (st_tip_x == $past(st_tip_x) && st_tip_r == $past(st_tip_r)))
    else $error("rejected move changed the tip");
`endif

endmodule

`default_nettype wire

[test/tb_two_link_arm_kinematics_core.sv]
`timescale 1ns / 100ps

module tb_two_link_arm_kinematics_core;
  import tlak_pkg::*;

  typedef struct {
    logic [1:0]         func;
    logic               as_delta;
    logic signed [18:0] pos_x;
    logic signed [18:0] pos_y;
    logic signed [18:0] radius;
    logic [15:0]        angle;
  } arm_cmd_t;

  typedef struct {
    logic               accepted;
    logic signed [18:0] tip_x;
    logic signed [18:0] tip_y;
    logic [17:0]        tip_radius;
    logic [15:0]        tip_angle;
    logic signed [18:0] elbow_x;
    logic signed [18:0] elbow_y;
    logic [15:0]        shoulder_angle;
    logic [15:0]        elbow_angle;
    logic [15:0]        link_two_angle;
  } arm_pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FUNC_SET_XY;
  logic as_delta = 1'b0;
  logic signed [18:0] pos_x = '0;
  logic signed [18:0] pos_y = '0;
  logic signed [18:0] radius = '0;
  logic [15:0] angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic signed [18:0] tip_x, tip_y, elbow_x, elbow_y;
  logic [17:0] tip_radius;
  logic [15:0] tip_angle, shoulder_angle, elbow_angle, link_two_angle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_LEN_AB;
  logic [15:0] cfg_data = '0;

  two_link_arm_kinematics_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .as_delta(as_delta), .pos_x(pos_x), .pos_y(pos_y),
    .radius(radius), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .tip_x(tip_x), .tip_y(tip_y), .tip_radius(tip_radius),
    .tip_angle(tip_angle), .elbow_x(elbow_x), .elbow_y(elbow_y),
    .shoulder_angle(shoulder_angle), .elbow_angle(elbow_angle),
    .link_two_angle(link_two_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Arctangent of 2^-i in turns scaled by 2^32.
  longint arc_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861};

  // Pose and link settings as the block should hold them.
  longint arm_lab = 256, arm_lbc = 256;
  bit     arm_upper = 1'b1;
  longint arm_tx = 0, arm_ty = 0, arm_tr = 0, arm_ex = 0, arm_ey = 0;
  bit [15:0] arm_ta = '0, arm_sh = '0, arm_el = '0;

  arm_cmd_t  pending_cmds[$];
  arm_pose_t pose_fifo[$];
  int snd_idle = 0, rcv_idle = 0;
  bit hold_rx = 1'b0;
  bit press_go = 1'b0;
  int n_cmds = 0, n_poses = 0, n_acc = 0, n_cfg = 0, n_bad = 0;

  function automatic longint sat_pos(longint v);
    return v > 262143 ? 262143 : (v < -262144 ? -262144 : v);
  endfunction

  function automatic longint rnd30(longint v);
    return (v + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic longint isqrt(longint n);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Rotation-mode CORDIC, results in Q2.30.
  function automatic void sin_cos(input bit [15:0] ang, output longint c, output longint s);
    bit [31:0] a, t;
    bit flip;
    longint x, y, z, dx, dy;
    a = {ang, 16'h0000};
    t = a + 32'h4000_0000;
    flip = t[31];
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arc_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + arc_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring-mode CORDIC bearing, rounded to 16 bits.
  function automatic bit [15:0] bearing(longint x, longint y);
    bit [31:0] z, t;
    longint dx, dy;
    z = '0;
    if (x == 0 && y == 0) return 16'h0000;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx; y = y + dy; z = z - 32'(arc_tab[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + 32'(arc_tab[i]);
      end
    end
    t = z + 32'h0000_8000;
    return t[31:16];
  endfunction

  function automatic bit [15:0] arc_cos(longint num, longint den);
    longint c, one;
    one = longint'(1) << 24;
    if (den <= 0) c = num > 0 ? one : (num < 0 ? -one : 0);
    else if (num >= den) c = one;
    else if (num <= -den) c = -one;
    else c = num * one / den;
    return bearing(c, isqrt(one * one - c * c));
  endfunction

  function automatic bit in_reach(longint r);
    return (arm_lab - arm_lbc < r) && (r < arm_lab + arm_lbc);
  endfunction

  function automatic void place_elbow();
    longint c, s;
    sin_cos(arm_sh, c, s);
    arm_ex = sat_pos(rnd30(arm_lab * c));
    arm_ey = sat_pos(rnd30(arm_lab * s));
  endfunction

  // Law of cosines for both joints, then the elbow follows the shoulder.
  function automatic void solve_joints();
    bit [15:0] alpha;
    arm_el = arc_cos(arm_lab * arm_lab + arm_lbc * arm_lbc - arm_tr * arm_tr,
                     2 * arm_lab * arm_lbc);
    alpha = arc_cos(arm_lab * arm_lab + arm_tr * arm_tr - arm_lbc * arm_lbc,
                    2 * arm_lab * arm_tr);
    arm_sh = arm_ta + (arm_upper ? alpha : 16'(-alpha));
    place_elbow();
  endfunction

  function automatic bit move_polar(longint r, bit [15:0] a);
    longint c, s;
    if (!in_reach(r)) return 1'b0;
    sin_cos(a, c, s);
    arm_tx = sat_pos(rnd30(r * c));
    arm_ty = sat_pos(rnd30(r * s));
    arm_tr = r;
    arm_ta = a;
    solve_joints();
    return 1'b1;
  endfunction

  // Applies one command to the pose and returns the pose that should follow.
  function automatic arm_pose_t next_pose(arm_cmd_t cmd);
    arm_pose_t p;
    bit acc;
    longint nx, ny, nr, c, s;
    bit [15:0] na, t;
    acc = 1'b0;
    case (cmd.func)
      FUNC_SET_XY: begin
        nx = sat_pos(cmd.as_delta ? arm_tx + cmd.pos_x : longint'(cmd.pos_x));
        ny = sat_pos(cmd.as_delta ? arm_ty + cmd.pos_y : longint'(cmd.pos_y));
        nr = isqrt(nx * nx + ny * ny);
        if (nr > 262143) nr = 262143;
        na = bearing(nx * 256, ny * 256);
        if (in_reach(nr)) begin
          arm_tx = nx; arm_ty = ny; arm_tr = nr; arm_ta = na;
          solve_joints();
          acc = 1'b1;
        end
      end
      FUNC_SET_POLAR: begin
        nr = cmd.as_delta ? arm_tr + cmd.radius : longint'(cmd.radius);
        if (nr < 0) nr = 0;
        if (nr > 262143) nr = 262143;
        acc = move_polar(nr, cmd.as_delta ? arm_ta + cmd.angle : cmd.angle);
      end
      FUNC_SET_SHOULDER: begin
        if (!cmd.as_delta || cmd.angle != 0) begin
          na = cmd.as_delta ? cmd.angle : 16'(cmd.angle - arm_sh);
          acc = move_polar(arm_tr, 16'(arm_ta + na));
        end
      end
      default: begin
        arm_el = cmd.as_delta ? 16'(arm_el + cmd.angle) : cmd.angle;
        if (arm_upper) t = arm_sh + arm_el - 16'h8000;
        else t = arm_sh + 16'h8000 - arm_el;
        sin_cos(t, c, s);
        arm_tx = sat_pos(arm_ex + rnd30(arm_lbc * c));
        arm_ty = sat_pos(arm_ey + rnd30(arm_lbc * s));
        nr = isqrt(arm_tx * arm_tx + arm_ty * arm_ty);
        arm_tr = nr > 262143 ? 262143 : nr;
        arm_ta = bearing(arm_tx * 256, arm_ty * 256);
        acc = 1'b1;
      end
    endcase
    p.accepted = acc;
    p.tip_x = 19'(arm_tx);
    p.tip_y = 19'(arm_ty);
    p.tip_radius = 18'(arm_tr);
    p.tip_angle = arm_ta;
    p.elbow_x = 19'(arm_ex);
    p.elbow_y = 19'(arm_ey);
    p.shoulder_angle = arm_sh;
    p.elbow_angle = arm_el;
    p.link_two_angle = (arm_upper ? arm_sh : 16'(-arm_sh)) + arm_el;
    return p;
  endfunction

  // Driver: offers the oldest pending command and predicts on each accepted beat.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pose_fifo.push_back(next_pose(pending_cmds[0]));
        pending_cmds.pop_front();
        n_cmds++;
      end
      if (in_valid && !in_ready) offer = 1'b1;
      else offer = pending_cmds.size() > 0 && $urandom_range(99) >= snd_idle;
      if (offer) begin
        func <= pending_cmds[0].func;
        as_delta <= pending_cmds[0].as_delta;
        pos_x <= pending_cmds[0].pos_x;
        pos_y <= pending_cmds[0].pos_y;
        radius <= pending_cmds[0].radius;
        angle <= pending_cmds[0].angle;
      end
      in_valid <= offer;
    end
  end

  // Monitor: checks each result beat against the oldest predicted pose.
  always @(posedge clk) begin
    arm_pose_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{accepted, tip_x, tip_y, tip_radius, tip_angle, elbow_x, elbow_y,
                shoulder_angle, elbow_angle, link_two_angle};
        n_poses++;
        if (got.accepted) n_acc++;
        if (pose_fifo.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = pose_fifo.pop_front();
          if (got != want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("pose mismatch on result %0d", n_poses);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      out_ready <= !hold_rx && $urandom_range(99) >= rcv_idle;
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin
    wait (press_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_LEN_AB: arm_lab = val;
      CFG_LEN_BC: arm_lbc = val;
      default:    arm_upper = val[0];
    endcase
  endtask

  task automatic set_arm(input logic [15:0] lab, input logic [15:0] lbc, input bit up);
    cfg_write(CFG_LEN_AB, lab);
    cfg_write(CFG_LEN_BC, lbc);
    cfg_write(CFG_ELBOW_UPPER, {15'd0, up});
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || pose_fifo.size() != 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic push_cmd(input logic [1:0] f, input bit d, input int x, input int y,
                          input int r, input int a);
    arm_cmd_t c;
    c.func = f;
    c.as_delta = d;
    c.pos_x = 19'(x);
    c.pos_y = 19'(y);
    c.radius = 19'(r);
    c.angle = 16'(a);
    pending_cmds.push_back(c);
  endtask

  // Mostly reachable targets with random content, some raw noise.
  task automatic push_random(input int count);
    longint lo, hi, r;
    real th;
    int dr;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15) begin
        push_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        lo = arm_lab > arm_lbc ? arm_lab - arm_lbc : arm_lbc - arm_lab;
        hi = arm_lab + arm_lbc;
        if (hi > 262143) hi = 262143;
        if (hi - lo >= 2) r = $urandom_range(32'(hi - 1), 32'(lo + 1));
        else r = $urandom_range(1000);
        th = $urandom_range(65535) * 6.283185307 / 65536.0;
        dr = 32'(hi / 8) + 1;
        if ($urandom_range(99) < 25) begin
          push_cmd($urandom, 1'b1, $signed($urandom_range(2 * dr)) - dr,
                   $signed($urandom_range(2 * dr)) - dr,
                   $signed($urandom_range(2 * dr)) - dr, $urandom_range(4095) - 2048);
        end else begin
          push_cmd($urandom, 1'b0, $rtoi(r * $cos(th)), $rtoi(r * $sin(th)),
                   32'(r), $urandom_range(65535));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    snd_idle = 20;
    rcv_idle = 56;

    // Directed checks at the reset link lengths.
    set_arm(16'd256, 16'd256, 1'b1);
    push_cmd(FUNC_SET_XY, 0, 0, 0, 0, 0);
    push_cmd(FUNC_SET_SHOULDER, 1, 0, 0, 0, 0);
    push_cmd(FUNC_SET_XY, 0, 256, 0, 0, 0);
    push_cmd(FUNC_SET_XY, 0, -300, 10, 0, 0);
    push_cmd(FUNC_SET_XY, 0, 262143, 262143, 0, 0);
    push_cmd(FUNC_SET_XY, 0, -262144, -262144, 0, 0);
    push_cmd(FUNC_SET_XY, 1, 40, -30, 0, 0);
    push_cmd(FUNC_SET_XY, 1, 262143, 0, 0, 0);
    push_cmd(FUNC_SET_POLAR, 0, 0, 0, -262144, 16'hFFFF);
    push_cmd(FUNC_SET_POLAR, 0, 0, 0, 262143, 0);
    push_cmd(FUNC_SET_POLAR, 0, 0, 0, 256, 16'hC000);
    push_cmd(FUNC_SET_POLAR, 1, 0, 0, 50, 16'h1000);
    push_cmd(FUNC_SET_POLAR, 1, 0, 0, -262144, 0);
    push_cmd(FUNC_SET_SHOULDER, 0, 0, 0, 0, 16'h4000);
    push_cmd(FUNC_SET_SHOULDER, 1, 0, 0, 0, 16'h8000);
    push_cmd(FUNC_SET_SHOULDER, 1, 0, 0, 0, 0);
    push_cmd(FUNC_SET_ELBOW, 0, 0, 0, 0, 0);
    push_cmd(FUNC_SET_ELBOW, 0, 0, 0, 0, 16'h8000);
    push_cmd(FUNC_SET_ELBOW, 0, 0, 0, 0, 16'hFFFF);
    push_cmd(FUNC_SET_ELBOW, 1, 0, 0, 0, 16'h2000);
    push_cmd(FUNC_SET_XY, 0, 300, 200, 0, 0);
    wait_idle();

    // Longest links, lower elbow solution.
    set_arm(16'hFFFF, 16'hFFFF, 1'b0);
    push_random(200);
    wait_idle();

    // Sender and receiver swap idle rates; one long output stall.
    snd_idle = 56;
    rcv_idle = 20;
    set_arm(16'd0, 16'd700, 1'b1);
    press_go = 1'b1;
    push_random(150);
    wait_idle();

    set_arm(16'd1200, 16'd0, 1'b0);
    push_random(150);
    wait_idle();

    // Full rate on both sides.
    snd_idle = 0;
    rcv_idle = 0;
    set_arm(16'd5000, 16'd3000, 1'b1);
    push_random(250);
    wait_idle();

    $display("covered %0d commands and %0d results (%0d applied) over %0d register writes",
             n_cmds, n_poses, n_acc, n_cfg);
    $display("link settings ranged from zero length to full scale, both elbow solutions");
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches: %0d", n_bad);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tlak_pkg.sv
hdl/tlak_cordic.sv
hdl/tlak_sqrt.sv
hdl/two_link_arm_kinematics_core.sv
test/tb_two_link_arm_kinematics_core.sv
